// File: hw/rtl/ccir_pkg.sv
`timescale 1ns / 1ps

package ccir_pkg;

    localparam int BODY_SLOTS = 64;
    localparam int SLOT_W     = $clog2(BODY_SLOTS);

    // shared divider: 48-bit dividend, 32-bit divisor, quotient known below 2^17
    localparam int DIV_NUM_W = 48;
    localparam int DIV_DEN_W = 32;
    localparam int DIV_Q_W   = 17;

    localparam int SQRT_IN_W  = 64;
    localparam int SQRT_OUT_W = SQRT_IN_W / 2;

    typedef enum logic {
        OP_WRITE   = 1'b0,
        OP_RESOLVE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        OUT_APART      = 2'd0,
        OUT_RESOLVED   = 2'd1,
        OUT_SEPARATING = 2'd2,
        OUT_DEGENERATE = 2'd3
    } t_outcome;

    typedef struct packed {
        logic               kind;
        logic        [5:0]  slot_a;
        logic        [5:0]  slot_b;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic        [24:0] inv_mass;
        logic        [16:0] bounce;
        logic        [30:0] radius;
    } t_in_item;

    typedef struct packed {
        logic        [5:0]  slot;
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic        [1:0]  outcome;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic        [24:0] inv_mass;
        logic        [16:0] bounce;
        logic        [30:0] radius;
    } t_body;

    typedef struct packed {
        t_op               op;
        logic [SLOT_W-1:0] a;
        logic [SLOT_W-1:0] b;
        t_body             body;
    } t_cmd;

    // divide by 65536, truncating toward zero
    function automatic logic signed [63:0] sdiv16(input logic signed [63:0] x);
        logic signed [63:0] t;
        t = x[63] ? (x + 64'sd65535) : x;
        return t >>> 16;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (x < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/ccir_front.sv
`timescale 1ns / 1ps

module ccir_front import ccir_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    output logic     o_cmd_valid,
    input  logic     i_cmd_ready,
    output t_cmd     o_cmd
);

    localparam int QDEPTH = 2;
    localparam int Q_AW   = $clog2(QDEPTH);

    t_cmd            r_q [QDEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_AW:0]   r_cnt;
    t_cmd            w_cmd;
    logic            w_push;
    logic            w_pop;

    // classify and wrap slot indexes
    always_comb begin
        w_cmd.op            = i_item.kind ? OP_RESOLVE : OP_WRITE;
        w_cmd.a             = i_item.slot_a[SLOT_W-1:0];
        w_cmd.b             = i_item.slot_b[SLOT_W-1:0];
        w_cmd.body.pos_x    = i_item.pos_x;
        w_cmd.body.pos_y    = i_item.pos_y;
        w_cmd.body.vel_x    = i_item.vel_x;
        w_cmd.body.vel_y    = i_item.vel_y;
        w_cmd.body.inv_mass = i_item.inv_mass;
        w_cmd.body.bounce   = i_item.bounce;
        w_cmd.body.radius   = i_item.radius;
    end

    assign o_ready     = (r_cnt != (Q_AW+1)'(QDEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = i_valid && o_ready;
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (Q_AW+1)'(QDEPTH))
        else $error("queue count beyond depth");

endmodule

// File: hw/rtl/ccir_sqrt.sv
`timescale 1ns / 1ps

module ccir_sqrt import ccir_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [SQRT_IN_W-1:0]  i_val,
    output logic                  o_done,
    output logic [SQRT_OUT_W-1:0] o_root
);

    localparam int REM_W = SQRT_OUT_W + 4;
    localparam int CNT_W = $clog2(SQRT_OUT_W);

    logic [SQRT_IN_W-1:0]  r_val;
    logic [REM_W-1:0]      r_rem;
    logic [SQRT_OUT_W-1:0] r_root;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic [REM_W-1:0]      w_rem2;
    logic [REM_W-1:0]      w_trial;
    logic                  w_ge;

    // one root bit per step: bring down two radicand bits, try 4*root+1
    assign w_rem2  = {r_rem[REM_W-3:0], r_val[SQRT_IN_W-1 -: 2]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_ge    = (w_rem2 >= w_trial);
    assign o_done  = r_done;
    assign o_root  = r_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_val  <= i_val;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_rem  <= w_ge ? (w_rem2 - w_trial) : w_rem2;
                r_root <= {r_root[SQRT_OUT_W-2:0], w_ge};
                r_val  <= {r_val[SQRT_IN_W-3:0], 2'b00};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SQRT_OUT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// File: hw/rtl/ccir_div.sv
`timescale 1ns / 1ps

module ccir_div import ccir_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DIV_NUM_W-1:0] i_num,
    input  logic [DIV_DEN_W-1:0] i_den,
    output logic                 o_done,
    output logic [DIV_Q_W-1:0]   o_quo
);

    localparam int CNT_W = $clog2(DIV_Q_W);

    logic [DIV_DEN_W:0]   r_rem;
    logic [DIV_Q_W-1:0]   r_lo;
    logic [DIV_DEN_W-1:0] r_den;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [DIV_DEN_W+1:0] w_trial;
    logic [DIV_DEN_W+1:0] w_diff;
    logic                 w_ge;

    // restoring division, one quotient bit per cycle; quotient bits shift into r_lo
    assign w_trial = {r_rem, r_lo[DIV_Q_W-1]};
    assign w_diff  = w_trial - {2'b00, r_den};
    assign w_ge    = (w_trial >= {2'b00, r_den});
    assign o_done  = r_done;
    assign o_quo   = r_lo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= (DIV_DEN_W+1)'(i_num[DIV_NUM_W-1:DIV_Q_W]);
                r_lo   <= i_num[DIV_Q_W-1:0];
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem  <= w_ge ? w_diff[DIV_DEN_W:0] : w_trial[DIV_DEN_W:0];
                r_lo   <= {r_lo[DIV_Q_W-2:0], w_ge};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_Q_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// File: hw/rtl/ccir_back.sv
`timescale 1ns / 1ps

module ccir_back import ccir_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    output logic      o_cmd_ready,
    input  t_cmd      i_cmd,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    typedef enum logic [4:0] {
        S_IDLE, S_RDA, S_RDB, S_GEOM, S_CHK, S_MUL, S_SUM, S_CMP, S_SQRT,
        S_DIVX, S_DIVY, S_VAN1, S_VAN2, S_QMUL, S_QDIV, S_DIVA, S_DIVB,
        S_DVMUL, S_DVDIV, S_PROD, S_APPLY, S_EMITA, S_EMITB
    } t_state;

    t_state r_state;

    t_body r_mem [BODY_SLOTS];
    t_body r_rd;

    logic              w_we;
    logic [SLOT_W-1:0] w_waddr;
    t_body             w_wdata;
    logic [SLOT_W-1:0] w_raddr;

    logic [SLOT_W-1:0] r_a;
    logic [SLOT_W-1:0] r_b;
    t_body             r_ba;
    t_body             r_bb;
    t_outcome          r_outc;

    logic signed [32:0] r_dx;
    logic signed [32:0] r_dy;
    logic signed [32:0] r_dvx;
    logic signed [32:0] r_dvy;
    logic        [31:0] r_rs;
    logic        [31:0] r_adx;
    logic        [31:0] r_ady;
    logic        [63:0] r_sx;
    logic        [63:0] r_sy;
    logic        [63:0] r_rs2;
    logic        [64:0] r_dsq;
    logic        [31:0] r_dist;
    logic signed [17:0] r_nx;
    logic signed [17:0] r_ny;
    logic signed [50:0] r_px;
    logic signed [50:0] r_py;
    logic signed [35:0] r_van;
    logic signed [18:0] r_eone;
    logic signed [55:0] r_qp;
    logic signed [39:0] r_q;
    logic        [16:0] r_ra;
    logic        [16:0] r_rb;
    logic signed [57:0] r_dvap;
    logic signed [57:0] r_dvbp;
    logic signed [41:0] r_dva;
    logic signed [41:0] r_dvb;
    logic        [31:0] r_half;
    logic signed [59:0] r_pvxa;
    logic signed [59:0] r_pvya;
    logic signed [59:0] r_pvxb;
    logic signed [59:0] r_pvyb;
    logic signed [50:0] r_phx;
    logic signed [50:0] r_phy;

    t_out_item r_out;
    logic      r_o_valid;
    logic      w_out_free;

    logic [32:0]          w_adx;
    logic [32:0]          w_ady;
    logic                 w_apart_sq;
    logic                 w_dsq_zero;
    logic signed [51:0]   w_van32;
    logic [25:0]          w_isum;
    logic [16:0]          w_emin;
    logic signed [17:0]   w_quo_s;

    logic                  w_sqrt_start;
    logic                  w_sqrt_done;
    logic [SQRT_OUT_W-1:0] w_root;
    logic                  w_div_start;
    logic [DIV_NUM_W-1:0]  w_div_num;
    logic [DIV_DEN_W-1:0]  w_div_den;
    logic                  w_div_done;
    logic [DIV_Q_W-1:0]    w_quo;

    ccir_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sqrt_start),
        .i_val   (r_dsq[SQRT_IN_W-1:0]),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    ccir_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd <= r_mem[w_raddr];
    end

    assign w_out_free = !r_o_valid || i_ready;
    assign o_valid    = r_o_valid;
    assign o_item     = r_out;

    assign w_adx      = r_dx[32] ? 33'(-r_dx) : 33'(r_dx);
    assign w_ady      = r_dy[32] ? 33'(-r_dy) : 33'(r_dy);
    assign w_apart_sq = r_dsq[64] || (r_dsq[63:0] >= r_rs2);
    assign w_dsq_zero = (r_dsq == '0);
    assign w_van32    = 52'(r_px) + 52'(r_py);
    assign w_isum     = {1'b0, r_ba.inv_mass} + {1'b0, r_bb.inv_mass};
    assign w_emin     = (r_ba.bounce < r_bb.bounce) ? r_ba.bounce : r_bb.bounce;
    assign w_quo_s    = $signed({1'b0, w_quo});

    always_comb begin
        w_we         = 1'b0;
        w_waddr      = r_a;
        w_wdata      = r_ba;
        w_raddr      = r_a;
        o_cmd_ready  = 1'b0;
        w_sqrt_start = 1'b0;
        w_div_start  = 1'b0;
        w_div_num    = '0;
        w_div_den    = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd_ready = 1'b1;
                w_raddr     = i_cmd.a;
                if (i_cmd_valid && i_cmd.op == OP_WRITE) begin
                    w_we    = 1'b1;
                    w_waddr = i_cmd.a;
                    w_wdata = i_cmd.body;
                end
            end
            S_RDA: begin
                w_raddr = r_b;
            end
            S_CMP: begin
                w_sqrt_start = !w_apart_sq && !w_dsq_zero;
            end
            S_SQRT: begin
                w_div_start = w_sqrt_done;
                w_div_num   = {r_adx, 16'h0000};
                w_div_den   = w_root;
            end
            S_DIVX: begin
                w_div_start = w_div_done;
                w_div_num   = {r_ady, 16'h0000};
                w_div_den   = r_dist;
            end
            S_QDIV: begin
                w_div_start = 1'b1;
                w_div_num   = DIV_NUM_W'({r_ba.inv_mass, 16'h0000});
                w_div_den   = DIV_DEN_W'(w_isum);
            end
            S_DIVA: begin
                w_div_start = w_div_done;
                w_div_num   = DIV_NUM_W'({r_bb.inv_mass, 16'h0000});
                w_div_den   = DIV_DEN_W'(w_isum);
            end
            S_EMITA: begin
                w_we    = w_out_free && (r_outc == OUT_RESOLVED);
                w_waddr = r_a;
                w_wdata = r_ba;
            end
            S_EMITB: begin
                w_we    = w_out_free && (r_outc == OUT_RESOLVED);
                w_waddr = r_b;
                w_wdata = r_bb;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid && i_cmd.op == OP_RESOLVE) begin
                        r_a     <= i_cmd.a;
                        r_b     <= i_cmd.b;
                        r_state <= S_RDA;
                    end
                end
                S_RDA: begin
                    r_ba    <= r_rd;
                    r_state <= S_RDB;
                end
                S_RDB: begin
                    r_bb    <= r_rd;
                    r_state <= S_GEOM;
                end
                S_GEOM: begin
                    r_dx    <= 33'(r_bb.pos_x) - 33'(r_ba.pos_x);
                    r_dy    <= 33'(r_bb.pos_y) - 33'(r_ba.pos_y);
                    r_dvx   <= 33'(r_bb.vel_x) - 33'(r_ba.vel_x);
                    r_dvy   <= 33'(r_bb.vel_y) - 33'(r_ba.vel_y);
                    r_rs    <= {1'b0, r_ba.radius} + {1'b0, r_bb.radius};
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    r_adx <= w_adx[31:0];
                    r_ady <= w_ady[31:0];
                    if (w_adx >= {1'b0, r_rs} || w_ady >= {1'b0, r_rs}) begin
                        r_outc  <= OUT_APART;
                        r_state <= S_EMITA;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_sx    <= r_adx * r_adx;
                    r_sy    <= r_ady * r_ady;
                    r_rs2   <= r_rs * r_rs;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_dsq   <= {1'b0, r_sx} + {1'b0, r_sy};
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (w_apart_sq) begin
                        r_outc  <= OUT_APART;
                        r_state <= S_EMITA;
                    end else if (w_dsq_zero) begin
                        r_outc  <= OUT_DEGENERATE;
                        r_state <= S_EMITA;
                    end else begin
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (w_sqrt_done) begin
                        r_dist  <= w_root;
                        r_state <= S_DIVX;
                    end
                end
                S_DIVX: begin
                    if (w_div_done) begin
                        r_nx    <= r_dx[32] ? -w_quo_s : w_quo_s;
                        r_state <= S_DIVY;
                    end
                end
                S_DIVY: begin
                    if (w_div_done) begin
                        r_ny    <= r_dy[32] ? -w_quo_s : w_quo_s;
                        r_state <= S_VAN1;
                    end
                end
                S_VAN1: begin
                    r_px    <= r_dvx * r_nx;
                    r_py    <= r_dvy * r_ny;
                    r_state <= S_VAN2;
                end
                S_VAN2: begin
                    r_van  <= 36'(sdiv16(64'(w_van32)));
                    r_eone <= $signed({2'b00, w_emin}) + 19'sd65536;
                    if (w_van32 > 52'sd0) begin
                        r_outc  <= OUT_SEPARATING;
                        r_state <= S_EMITA;
                    end else if (w_isum == '0) begin
                        r_outc  <= OUT_DEGENERATE;
                        r_state <= S_EMITA;
                    end else begin
                        r_state <= S_QMUL;
                    end
                end
                S_QMUL: begin
                    r_qp    <= r_eone * r_van;
                    r_state <= S_QDIV;
                end
                S_QDIV: begin
                    r_q     <= 40'(sdiv16(-64'(r_qp)));
                    r_state <= S_DIVA;
                end
                S_DIVA: begin
                    if (w_div_done) begin
                        r_ra    <= w_quo;
                        r_state <= S_DIVB;
                    end
                end
                S_DIVB: begin
                    if (w_div_done) begin
                        r_rb    <= w_quo;
                        r_state <= S_DVMUL;
                    end
                end
                S_DVMUL: begin
                    r_dvap  <= r_q * $signed({1'b0, r_ra});
                    r_dvbp  <= r_q * $signed({1'b0, r_rb});
                    r_state <= S_DVDIV;
                end
                S_DVDIV: begin
                    r_dva   <= 42'(sdiv16(64'(r_dvap)));
                    r_dvb   <= 42'(sdiv16(64'(r_dvbp)));
                    r_half  <= (r_rs - r_dist) >> 1;
                    r_state <= S_PROD;
                end
                S_PROD: begin
                    r_pvxa  <= r_nx * r_dva;
                    r_pvya  <= r_ny * r_dva;
                    r_pvxb  <= r_nx * r_dvb;
                    r_pvyb  <= r_ny * r_dvb;
                    r_phx   <= r_nx * $signed({1'b0, r_half});
                    r_phy   <= r_ny * $signed({1'b0, r_half});
                    r_state <= S_APPLY;
                end
                S_APPLY: begin
                    r_ba.vel_x <= sat32(64'(r_ba.vel_x) - sdiv16(64'(r_pvxa)));
                    r_ba.vel_y <= sat32(64'(r_ba.vel_y) - sdiv16(64'(r_pvya)));
                    r_bb.vel_x <= sat32(64'(r_bb.vel_x) + sdiv16(64'(r_pvxb)));
                    r_bb.vel_y <= sat32(64'(r_bb.vel_y) + sdiv16(64'(r_pvyb)));
                    r_ba.pos_x <= sat32(64'(r_ba.pos_x) - sdiv16(64'(r_phx)));
                    r_ba.pos_y <= sat32(64'(r_ba.pos_y) - sdiv16(64'(r_phy)));
                    r_bb.pos_x <= sat32(64'(r_bb.pos_x) + sdiv16(64'(r_phx)));
                    r_bb.pos_y <= sat32(64'(r_bb.pos_y) + sdiv16(64'(r_phy)));
                    r_outc     <= OUT_RESOLVED;
                    r_state    <= S_EMITA;
                end
                S_EMITA: begin
                    if (w_out_free) begin
                        r_out.slot      <= 6'(r_a);
                        r_out.new_pos_x <= r_ba.pos_x;
                        r_out.new_pos_y <= r_ba.pos_y;
                        r_out.new_vel_x <= r_ba.vel_x;
                        r_out.new_vel_y <= r_ba.vel_y;
                        r_out.outcome   <= r_outc;
                        r_out.last      <= 1'b0;
                        r_o_valid       <= 1'b1;
                        r_state         <= S_EMITB;
                    end
                end
                S_EMITB: begin
                    if (w_out_free) begin
                        r_out.slot      <= 6'(r_b);
                        r_out.new_pos_x <= r_bb.pos_x;
                        r_out.new_pos_y <= r_bb.pos_y;
                        r_out.new_vel_x <= r_bb.vel_x;
                        r_out.new_vel_y <= r_bb.vel_y;
                        r_out.outcome   <= r_outc;
                        r_out.last      <= 1'b1;
                        r_o_valid       <= 1'b1;
                        r_state         <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_we_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_IDLE || r_state == S_EMITA || r_state == S_EMITB))
        else $error("body table written outside write or emit");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMITA && w_out_free) |=> (r_state == S_EMITB && r_o_valid))
        else $error("second body result does not follow the first");

    a_normal_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVX && w_div_done) |-> (w_quo <= 17'd65536))
        else $error("normal component above one");

endmodule

// File: hw/rtl/circle_contact_impulse_resolver_unit.sv
`timescale 1ns / 1ps
// Circle contact resolver over a table of 64 circular bodies.
// Input channel (i_valid / o_ready, payload i_item): a write transaction
// (kind 0) stores one body into slot_a and returns nothing; a resolve
// transaction (kind 1) tests bodies slot_a and slot_b; for an approaching
// contact it applies the restitution impulse and half-overlap push-apart and
// writes both back; two results return, body A first, then body B (last = 1).
// Output channel (o_valid / i_ready, payload o_item) has a result register.
// A two-entry queue sits between the input and the resolve sequencer, so
// input keeps flowing while the sequencer or a stalled receiver holds.
// Order: with the sequencer idle, a write passes from the queue into the
// table. A resolve of touching bodies with distinct centres runs a square
// root and then up to four divisions, one after another, on the one shared
// divider. One pair is resolved at a time. While i_ready is low the result
// holds and the sequencer waits; the queue fills, then o_ready drops.
// Reset (synchronous, active low) empties the queue and output; the body
// table is not cleared and reads of a never-written slot are undefined.

module circle_contact_impulse_resolver_unit import ccir_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    logic w_cmd_valid;
    logic w_cmd_ready;
    t_cmd w_cmd;

    ccir_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_item      (i_item),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_ready (w_cmd_ready),
        .o_cmd       (w_cmd)
    );

    ccir_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_cmd       (w_cmd),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_item      (o_item)
    );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import ccir_pkg::*;

    localparam int  HOLD_CYCLES = 600;
    localparam longint CYCLE_LIMIT = 2000000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_item  i_item = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_item o_item;

    circle_contact_impulse_resolver_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    // body table as the block should hold it
    longint          tbl_px[BODY_SLOTS];
    longint          tbl_py[BODY_SLOTS];
    longint          tbl_vx[BODY_SLOTS];
    longint          tbl_vy[BODY_SLOTS];
    longint          tbl_im[BODY_SLOTS];
    longint          tbl_bn[BODY_SLOTS];
    longint          tbl_rad[BODY_SLOTS];
    bit              written[BODY_SLOTS];

    t_out_item       pending_results[$];
    int              mismatches = 0;
    int              send_idle_pct = 0;
    int              recv_stall_pct = 0;
    logic            stall_hold = 1'b0;
    event            hold_go;
    longint          cycles = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    function automatic longint sat_q16(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned bt;
        r = 0;
        bt = 64'd1 << 62;
        while (bt > v) bt >>= 2;
        while (bt != 0) begin
            if (v >= r + bt) begin
                v -= r + bt;
                r = (r >> 1) + bt;
            end else begin
                r >>= 1;
            end
            bt >>= 2;
        end
        return r;
    endfunction

    // contact test and impulse on the table; returns the outcome code
    function automatic t_outcome resolve_contact(int a, int b);
        longint dx, dy, adx, ady, nx, ny, van32, van, e, q, dva, dvb, half, cdist;
        longint unsigned rs, sx, sy, dsq, ia, ib, isum, ra, rb;
        dx = tbl_px[b] - tbl_px[a];
        dy = tbl_py[b] - tbl_py[a];
        rs = tbl_rad[a] + tbl_rad[b];
        adx = dx < 0 ? -dx : dx;
        ady = dy < 0 ? -dy : dy;
        if (adx >= rs || ady >= rs) return OUT_APART;
        sx = adx * adx;
        sy = ady * ady;
        dsq = sx + sy;
        if (dsq < sx) return OUT_APART;
        if (dsq >= rs * rs) return OUT_APART;
        if (dsq == 0) return OUT_DEGENERATE;
        cdist = longint'(root_floor(dsq));
        nx = dx * 65536 / cdist;
        ny = dy * 65536 / cdist;
        van32 = (tbl_vx[b] - tbl_vx[a]) * nx + (tbl_vy[b] - tbl_vy[a]) * ny;
        if (van32 > 0) return OUT_SEPARATING;
        ia = tbl_im[a];
        ib = tbl_im[b];
        isum = ia + ib;
        if (isum == 0) return OUT_DEGENERATE;
        van = van32 / 65536;
        e = tbl_bn[a] < tbl_bn[b] ? tbl_bn[a] : tbl_bn[b];
        q = (65536 + e) * (-van) / 65536;
        ra = ia * 65536 / isum;
        rb = ib * 65536 / isum;
        dva = q * longint'(ra) / 65536;
        dvb = q * longint'(rb) / 65536;
        tbl_vx[a] = sat_q16(tbl_vx[a] - nx * dva / 65536);
        tbl_vy[a] = sat_q16(tbl_vy[a] - ny * dva / 65536);
        tbl_vx[b] = sat_q16(tbl_vx[b] + nx * dvb / 65536);
        tbl_vy[b] = sat_q16(tbl_vy[b] + ny * dvb / 65536);
        half = (longint'(rs) - cdist) / 2;
        tbl_px[a] = sat_q16(tbl_px[a] - nx * half / 65536);
        tbl_py[a] = sat_q16(tbl_py[a] - ny * half / 65536);
        tbl_px[b] = sat_q16(tbl_px[b] + nx * half / 65536);
        tbl_py[b] = sat_q16(tbl_py[b] + ny * half / 65536);
        return OUT_RESOLVED;
    endfunction

    function automatic t_out_item body_report(int s, t_outcome oc, logic lst);
        t_out_item r;
        r.slot      = s[5:0];
        r.new_pos_x = tbl_px[s][31:0];
        r.new_pos_y = tbl_py[s][31:0];
        r.new_vel_x = tbl_vx[s][31:0];
        r.new_vel_y = tbl_vy[s][31:0];
        r.outcome   = oc;
        r.last      = lst;
        return r;
    endfunction

    function automatic void predict_transaction(t_in_item it);
        int a, b;
        t_outcome oc;
        a = it.slot_a;
        b = it.slot_b;
        if (t_op'(it.kind) == OP_WRITE) begin
            tbl_px[a]  = it.pos_x;
            tbl_py[a]  = it.pos_y;
            tbl_vx[a]  = it.vel_x;
            tbl_vy[a]  = it.vel_y;
            tbl_im[a]  = it.inv_mass;
            tbl_bn[a]  = it.bounce;
            tbl_rad[a] = it.radius;
            written[a] = 1'b1;
        end else begin
            oc = resolve_contact(a, b);
            pending_results.push_back(body_report(a, oc, 1'b0));
            pending_results.push_back(body_report(b, oc, 1'b1));
        end
    endfunction

    task automatic send_item(t_in_item it);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        forever begin
            @(posedge i_clk);
            if (o_ready) break;
        end
        predict_transaction(it);
    endtask

    function automatic t_in_item body_write(int s, int px, int py, int vx, int vy,
                                            int im, int bn, int rad);
        t_in_item it;
        it.kind     = OP_WRITE;
        it.slot_a   = s[5:0];
        it.slot_b   = 6'($urandom());
        it.pos_x    = px;
        it.pos_y    = py;
        it.vel_x    = vx;
        it.vel_y    = vy;
        it.inv_mass = im[24:0];
        it.bounce   = bn[16:0];
        it.radius   = rad[30:0];
        return it;
    endfunction

    function automatic t_in_item pair_resolve(int a, int b);
        t_in_item     it;
        logic [223:0] raw;
        raw         = {$urandom(), $urandom(), $urandom(), $urandom(),
                       $urandom(), $urandom(), $urandom()};
        it          = raw[$bits(t_in_item)-1:0];
        it.kind     = OP_RESOLVE;
        it.slot_a   = a[5:0];
        it.slot_b   = b[5:0];
        return it;
    endfunction

    function automatic int written_slot();
        int s;
        do s = $urandom_range(BODY_SLOTS - 1); while (!written[s]);
        return s;
    endfunction

    // receiver side: check each result and pick the next ready level
    always @(posedge i_clk) begin
        t_out_item expd;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: slot %0d outcome %0d", o_item.slot,
                             o_item.outcome);
            end else begin
                expd = pending_results.pop_front();
                if (o_item.slot !== expd.slot || o_item.new_pos_x !== expd.new_pos_x ||
                    o_item.new_pos_y !== expd.new_pos_y ||
                    o_item.new_vel_x !== expd.new_vel_x ||
                    o_item.new_vel_y !== expd.new_vel_y ||
                    o_item.outcome !== expd.outcome || o_item.last !== expd.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp slot %0d p(%0d,%0d) v(%0d,%0d) oc %0d last %0d / act slot %0d p(%0d,%0d) v(%0d,%0d) oc %0d last %0d",
                                 expd.slot, expd.new_pos_x, expd.new_pos_y, expd.new_vel_x,
                                 expd.new_vel_y, expd.outcome, expd.last, o_item.slot,
                                 o_item.new_pos_x, o_item.new_pos_y, o_item.new_vel_x,
                                 o_item.new_vel_y, o_item.outcome, o_item.last);
                end
            end
        end
        if (stall_hold) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always begin
        @(hold_go);
        stall_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        stall_hold <= 1'b0;
    end

    task automatic test_directed();
        int one = 65536;
        send_item(body_write(0, 0, 0, one, 0, one, one, one));
        send_item(body_write(1, one + one / 2, 0, -one, 0, one, one / 2, one));
        send_item(pair_resolve(0, 1));
        send_item(pair_resolve(1, 0));
        // slot paired with itself, then coincident centres
        send_item(pair_resolve(0, 0));
        send_item(body_write(2, int'(tbl_px[0]), int'(tbl_py[0]), 0, 0, one, one, one));
        send_item(pair_resolve(0, 2));
        // separating pair
        send_item(body_write(3, 0, 0, -one, 0, one, one, one));
        send_item(body_write(4, one, one / 4, one, 0, one, one, one));
        send_item(pair_resolve(3, 4));
        // both immovable
        send_item(body_write(5, 0, 0, one, one, 0, one, one));
        send_item(body_write(6, one / 2, one / 2, -one, -one, 0, one, one));
        send_item(pair_resolve(5, 6));
        // extremes of every field
        send_item(body_write(63, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
                             32'h1FFFFFF, 32'h1FFFF, 32'h7FFFFFFF));
        send_item(body_write(62, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                             0, 0, 32'h7FFFFFFF));
        send_item(pair_resolve(62, 63));
        // overlapping at the top corner with huge approach: saturation
        send_item(body_write(61, 32'h7FF00000, 32'h7FF00000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                             32'h1000000, 65536, 32'h00400000));
        send_item(pair_resolve(61, 63));
        send_item(pair_resolve(63, 61));
        send_item(pair_resolve(62, 62));
    endtask

    task automatic contact_sequence();
        int a, b, ra, rb, s, bx, by, bump;
        a = $urandom_range(BODY_SLOTS - 1);
        do b = $urandom_range(BODY_SLOTS - 1); while (b == a);
        ra = $urandom_range(524288, 16384);
        rb = $urandom_range(524288, 16384);
        s  = ra + rb;
        bx = int'($urandom_range(1 << 24)) - (1 << 23);
        by = int'($urandom_range(1 << 24)) - (1 << 23);
        bump = $urandom_range(99);
        send_item(body_write(a, bx, by, int'($urandom_range(1 << 22)) - (1 << 21),
                             int'($urandom_range(1 << 22)) - (1 << 21),
                             bump < 10 ? 0 : $urandom_range(1 << 18),
                             $urandom_range(65536), ra));
        send_item(body_write(b, bx + int'($urandom_range(2 * s)) - s,
                             by + int'($urandom_range(2 * s)) - s,
                             int'($urandom_range(1 << 22)) - (1 << 21),
                             int'($urandom_range(1 << 22)) - (1 << 21),
                             bump < 20 ? 0 : $urandom_range(1 << 18),
                             $urandom_range(65536), rb));
        if ($urandom_range(1)) send_item(pair_resolve(a, b));
        else send_item(pair_resolve(b, a));
        if ($urandom_range(3) == 0) send_item(pair_resolve(a, b));
    endtask

    task automatic noise_item();
        int pick;
        pick = $urandom_range(9);
        if (pick < 4) begin
            send_item(body_write($urandom_range(BODY_SLOTS - 1), $urandom(), $urandom(),
                                 $urandom(), $urandom(), $urandom(), $urandom(),
                                 $urandom()));
        end else if (pick < 5) begin
            pick = written_slot();
            send_item(pair_resolve(pick, pick));
        end else begin
            send_item(pair_resolve(written_slot(), written_slot()));
        end
    endtask

    task automatic test_random(int items, int s_pct, int r_pct);
        int sent;
        send_idle_pct  = s_pct;
        recv_stall_pct = r_pct;
        sent = 0;
        while (sent < items) begin
            if ($urandom_range(99) < 75) begin
                contact_sequence();
                sent += 3;
            end else begin
                noise_item();
                sent += 1;
            end
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        -> hold_go;
        repeat (10) contact_sequence();
    endtask

    initial begin
        i_rst_n <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(230, 0, 0);
        test_random(230, 72, 0);
        test_random(230, 0, 72);
        test_random(230, 24, 24);
        test_backpressure();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/ccir_pkg.sv
hw/rtl/ccir_front.sv
hw/rtl/ccir_sqrt.sv
hw/rtl/ccir_div.sv
hw/rtl/ccir_back.sv
hw/rtl/circle_contact_impulse_resolver_unit.sv
tb/tb_top.sv
